### rtl/core/flipdot_delta_column_update_top_defines.svh
// Assertion macros of the flip-dot column update checker.
`ifndef FLIPDOT_DELTA_COLUMN_UPDATE_TOP_DEFINES_SVH
`define FLIPDOT_DELTA_COLUMN_UPDATE_TOP_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define FDCU_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define FDCU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/fdcu_pkg.sv
// Shared types, constants and helpers of the flip-dot column update block.
`default_nettype none

package fdcu_pkg;

   localparam int MATRIX_COLUMNS_DEF = 28;
   localparam int PANEL_COLUMNS_DEF  = 28;
   localparam int MATRIX_ROWS_DEF    = 16;

   localparam int COL_W    = 5;
   localparam int BITS_W   = 16;
   localparam int ADDR_W   = 5;
   localparam int LINE_W   = 4;
   localparam int PANEL_W  = 3;
   localparam int REM_W    = 5;
   localparam int CSR_IDX_W = 3;

   // Every eighth driver address is unused: one skip per seven columns.
   localparam logic [ADDR_W-1:0] SKIP_PERIOD = 5'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUICK_UPDATE  = 3'd0,
      CSR_INVERT_PIXELS = 3'd1,
      CSR_COL_SWAP      = 3'd2,
      CSR_ROW_SWAP      = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic               done;
      logic [REM_W-1:0]   remainder;
      logic [PANEL_W-1:0] panel;
   } div_result_type;

   // Map a column position within a panel (below 28) to its driver address.
   function automatic logic [ADDR_W-1:0] driver_address(input logic [REM_W-1:0] pos);
      logic [ADDR_W-1:0] skips;
      skips = ADDR_W'(pos >= SKIP_PERIOD) + ADDR_W'(pos >= 2 * SKIP_PERIOD)
            + ADDR_W'(pos >= 3 * SKIP_PERIOD) + ADDR_W'(pos >= 4 * SKIP_PERIOD);
      return pos + skips + ADDR_W'(1);
   endfunction

endpackage

`default_nettype wire

### rtl/core/flipdot_delta_column_update_top.sv
// Top level of the flip-dot column update command generator.
// Sequence: DW serial divide steps (DW = max(5, clog2 of the matrix width), 5 by default),
// an address step, then one row per cycle while the output is not stalled.
// Throughput: one column at a time; the next request waits until the column is done.
// Empty or out-of-range columns are dropped at accept and never enter the divider.
// Reset: synchronous; quick update on, no inversion, no swaps, no command pending.
`default_nettype none

module flipdot_delta_column_update_top #(
   parameter int MATRIX_COLUMNS = fdcu_pkg::MATRIX_COLUMNS_DEF,
   parameter int PANEL_COLUMNS  = fdcu_pkg::PANEL_COLUMNS_DEF,
   parameter int MATRIX_ROWS    = fdcu_pkg::MATRIX_ROWS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // column request channel
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [fdcu_pkg::COL_W-1:0]      req_column_index,
   input  wire logic [fdcu_pkg::BITS_W-1:0]     req_new_column_bits,
   input  wire logic [fdcu_pkg::BITS_W-1:0]     req_old_column_bits,
   input  wire logic                            req_have_old,
   // flip command channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [fdcu_pkg::ADDR_W-1:0]     rsp_column_address,
   output      logic [fdcu_pkg::LINE_W-1:0]     rsp_row_line,
   output      logic                            rsp_yellow,
   output      logic [fdcu_pkg::PANEL_W-1:0]    rsp_panel_index,
   output      logic                            rsp_last_flip,
   // register write channel
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [fdcu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic                            csr_data
);

   // Divider width covers every mirrored column index and the 5-bit input index.
   localparam int DW  = ($clog2(MATRIX_COLUMNS) > fdcu_pkg::COL_W) ?
                        $clog2(MATRIX_COLUMNS) : fdcu_pkg::COL_W;
   localparam int DW1 = DW + 1;
   localparam logic [DW:0]   COL_LIMIT = DW1'(MATRIX_COLUMNS);
   localparam logic [DW-1:0] COL_TOP   = DW'(MATRIX_COLUMNS - 1);
   localparam logic [fdcu_pkg::LINE_W-1:0] ROW_TOP = fdcu_pkg::LINE_W'(MATRIX_ROWS - 1);
   // Rows at or above the matrix height are never flipped.
   localparam logic [fdcu_pkg::BITS_W-1:0] ROW_MASK =
      fdcu_pkg::BITS_W'((33'd1 << MATRIX_ROWS) - 33'd1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN
   } state_type;

   state_type                        state_ff, state_in;
   logic                             quick_ff, quick_in;
   logic                             invert_ff, invert_in;
   logic                             col_swap_ff, col_swap_in;
   logic                             row_swap_ff, row_swap_in;
   logic [fdcu_pkg::BITS_W-1:0]      mask_ff, mask_in;
   logic [fdcu_pkg::BITS_W-1:0]      bits_ff, bits_in;
   logic [fdcu_pkg::LINE_W-1:0]      row_ff, row_in;
   logic [fdcu_pkg::ADDR_W-1:0]      addr_ff, addr_in;
   logic [fdcu_pkg::PANEL_W-1:0]     panel_ff, panel_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [fdcu_pkg::ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [fdcu_pkg::LINE_W-1:0]      rsp_line_ff, rsp_line_in;
   logic                             rsp_yellow_ff, rsp_yellow_in;
   logic [fdcu_pkg::PANEL_W-1:0]     rsp_panel_ff, rsp_panel_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             req_fire;
   logic                             delta;
   logic [fdcu_pkg::BITS_W-1:0]      req_mask;
   logic [DW-1:0]                    col_ext;
   logic [DW-1:0]                    col_rev;
   logic                             in_range;
   logic                             div_start;
   fdcu_pkg::div_result_type         div_result;
   logic [fdcu_pkg::BITS_W-1:0]      mask_rest;
   logic                             slot_free;
   logic                             advance;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Delta mode flips only changed rows; otherwise every row in the matrix.
   assign delta    = quick_ff && req_have_old;
   assign req_mask = (delta ? (req_new_column_bits ^ req_old_column_bits) : '1) & ROW_MASK;
   assign col_ext  = DW'(req_column_index);
   assign in_range = DW1'(req_column_index) < COL_LIMIT;
   // Reverse the column for the driver, unless the mirror is on (they cancel).
   assign col_rev  = col_swap_ff ? col_ext : (COL_TOP - col_ext);
   // Drop empty and out-of-range columns right at accept.
   assign div_start = req_fire && in_range && (req_mask != '0);

   fdcu_divider #(
      .DIVIDEND_W (DW),
      .DIVISOR    (PANEL_COLUMNS)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_a (col_rev),
      .dividend_b (col_ext),
      .result     (div_result)
   );

   assign mask_rest = mask_ff >> 1;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   // Skip unflipped rows freely; hold on a flipped row until the output slot frees.
   assign advance   = !mask_ff[0] || slot_free;

   always_comb begin
      state_in      = state_ff;
      quick_in      = quick_ff;
      invert_in     = invert_ff;
      col_swap_in   = col_swap_ff;
      row_swap_in   = row_swap_ff;
      mask_in       = mask_ff;
      bits_in       = bits_ff;
      row_in        = row_ff;
      addr_in       = addr_ff;
      panel_in      = panel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_line_in   = rsp_line_ff;
      rsp_yellow_in = rsp_yellow_ff;
      rsp_panel_in  = rsp_panel_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            fdcu_pkg::CSR_QUICK_UPDATE:  quick_in    = csr_data;
            fdcu_pkg::CSR_INVERT_PIXELS: invert_in   = csr_data;
            fdcu_pkg::CSR_COL_SWAP:      col_swap_in = csr_data;
            fdcu_pkg::CSR_ROW_SWAP:      row_swap_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               mask_in  = req_mask;
               bits_in  = req_new_column_bits;
               row_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_result.done) begin
               addr_in  = fdcu_pkg::driver_address(div_result.remainder);
               panel_in = div_result.panel;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (advance) begin
               if (mask_ff[0]) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = addr_ff;
                  rsp_line_in   = row_swap_ff ? row_ff : (ROW_TOP - row_ff);
                  rsp_yellow_in = bits_ff[0] ^ invert_ff;
                  rsp_panel_in  = panel_ff;
                  rsp_last_in   = (mask_rest == '0);
               end
               mask_in = mask_rest;
               bits_in = bits_ff >> 1;
               row_in  = row_ff + fdcu_pkg::LINE_W'(1);
               if (mask_rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         quick_ff     <= 1'b1;
         invert_ff    <= 1'b0;
         col_swap_ff  <= 1'b0;
         row_swap_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quick_ff     <= quick_in;
         invert_ff    <= invert_in;
         col_swap_ff  <= col_swap_in;
         row_swap_ff  <= row_swap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mask_ff       <= mask_in;
      bits_ff       <= bits_in;
      row_ff        <= row_in;
      addr_ff       <= addr_in;
      panel_ff      <= panel_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_line_ff   <= rsp_line_in;
      rsp_yellow_ff <= rsp_yellow_in;
      rsp_panel_ff  <= rsp_panel_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_column_address = rsp_addr_ff;
   assign rsp_row_line       = rsp_line_ff;
   assign rsp_yellow         = rsp_yellow_ff;
   assign rsp_panel_index    = rsp_panel_ff;
   assign rsp_last_flip      = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/core/fdcu_divider.sv
// Bit-serial restoring divider by the panel width: column remainder and panel quotient.
`default_nettype none

module fdcu_divider #(
   parameter int DIVIDEND_W = 5,
   parameter int DIVISOR    = fdcu_pkg::PANEL_COLUMNS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend_a,
   input  wire logic [DIVIDEND_W-1:0] dividend_b,
   output fdcu_pkg::div_result_type   result
);

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam int TRIAL_W = fdcu_pkg::REM_W + 1;
   localparam logic [TRIAL_W-1:0] DIVISOR_T = TRIAL_W'(DIVISOR);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0]        a_ff, a_in, b_ff, b_in;
   logic [fdcu_pkg::REM_W-1:0]   rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [TRIAL_W-1:0]           trial_a, trial_b;
   logic                         ge_a, ge_b;

   assign trial_a = {rem_a_ff, a_ff[DIVIDEND_W-1]};
   assign trial_b = {rem_b_ff, b_ff[DIVIDEND_W-1]};
   assign ge_a    = trial_a >= DIVISOR_T;
   assign ge_b    = trial_b >= DIVISOR_T;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(DIVIDEND_W - 1);
         a_in     = dividend_a;
         b_in     = dividend_b;
         rem_a_in = '0;
         rem_b_in = '0;
      end else if (busy_ff) begin
         // Shift one dividend bit in, subtract when it fits, shift quotient bit in.
         rem_a_in = ge_a ? fdcu_pkg::REM_W'(trial_a - DIVISOR_T) : trial_a[fdcu_pkg::REM_W-1:0];
         rem_b_in = ge_b ? fdcu_pkg::REM_W'(trial_b - DIVISOR_T) : trial_b[fdcu_pkg::REM_W-1:0];
         a_in     = {a_ff[DIVIDEND_W-2:0], ge_a};
         b_in     = {b_ff[DIVIDEND_W-2:0], ge_b};
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
   end

   assign result.done      = done_ff;
   assign result.remainder = rem_a_ff;
   assign result.panel     = b_ff[fdcu_pkg::PANEL_W-1:0];

endmodule

`default_nettype wire

### rtl/core/fdcu_checker.sv
// Port-level checker of the flip-dot column update block, bound to its top level.
`default_nettype none
`include "flipdot_delta_column_update_top_defines.svh"

module fdcu_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [fdcu_pkg::ADDR_W-1:0]     rsp_column_address,
   input wire logic [fdcu_pkg::LINE_W-1:0]     rsp_row_line,
   input wire logic                            rsp_yellow,
   input wire logic [fdcu_pkg::PANEL_W-1:0]    rsp_panel_index,
   input wire logic                            rsp_last_flip
);

   // A stalled command holds its payload.
   `FDCU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_column_address) && $stable(rsp_row_line) && $stable(rsp_yellow) && $stable(rsp_panel_index) && $stable(rsp_last_flip), "flip command changed while stalled")

   // While a column's commands are still coming, no new request is taken.
   `FDCU_ASSERT_SAME(a_busy_mid_column, clock, reset, rsp_valid && !rsp_last_flip, !req_ready, "request ready in the middle of a column")

   // The divide steps keep a new command from showing right after a request.
   `FDCU_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "command appeared one cycle after request")

endmodule

bind flipdot_delta_column_update_top fdcu_checker u_fdcu_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_column_address (rsp_column_address),
   .rsp_row_line       (rsp_row_line),
   .rsp_yellow         (rsp_yellow),
   .rsp_panel_index    (rsp_panel_index),
   .rsp_last_flip      (rsp_last_flip)
);

`default_nettype wire

### verif/flipdot_delta_column_update_top_test.sv
// Self-checking testbench for the flip-dot column update command generator.
`timescale 1ns / 100ps

module flipdot_delta_column_update_top_test;

   // Field widths of the block's ports.
   localparam int COL_W     = fdcu_pkg::COL_W;
   localparam int BITS_W    = fdcu_pkg::BITS_W;
   localparam int ADDR_W    = fdcu_pkg::ADDR_W;
   localparam int LINE_W    = fdcu_pkg::LINE_W;
   localparam int PANEL_W   = fdcu_pkg::PANEL_W;
   localparam int CSR_IDX_W = fdcu_pkg::CSR_IDX_W;
   // Geometry of the block as built with its default parameters.
   localparam int MATRIX_COLUMNS = fdcu_pkg::MATRIX_COLUMNS_DEF;
   localparam int PANEL_COLUMNS  = fdcu_pkg::PANEL_COLUMNS_DEF;
   localparam int MATRIX_ROWS    = fdcu_pkg::MATRIX_ROWS_DEF;
   // Driver addresses skip one slot after every seven columns.
   localparam int SKIP_SPAN      = 7;
   // Register indexes at or above this count are unused.
   localparam int CSR_REG_COUNT  = 4;
   localparam int CSR_IDX_MAX    = (1 << CSR_IDX_W) - 1;
   // Idle wait after the last check, before touching registers.
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_TRIGGER   = 25;
   localparam int HOLD_CYCLES    = 250;
   localparam int CYCLE_LIMIT    = 250000;

   typedef struct {
      logic [COL_W-1:0]  column_index;
      logic [BITS_W-1:0] new_column_bits;
      logic [BITS_W-1:0] old_column_bits;
      logic              have_old;
   } column_req_type;

   typedef struct {
      logic [ADDR_W-1:0]  column_address;
      logic [LINE_W-1:0]  row_line;
      logic               yellow;
      logic [PANEL_W-1:0] panel_index;
      logic               last_flip;
   } flip_cmd_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [COL_W-1:0]     req_column_index = '0;
   logic [BITS_W-1:0]    req_new_column_bits = '0;
   logic [BITS_W-1:0]    req_old_column_bits = '0;
   logic                 req_have_old = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ADDR_W-1:0]    rsp_column_address;
   logic [LINE_W-1:0]    rsp_row_line;
   logic                 rsp_yellow;
   logic [PANEL_W-1:0]   rsp_panel_index;
   logic                 rsp_last_flip;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic                 csr_data = 1'b0;

   // Shadow copy of the register file, updated when a write is accepted.
   logic cfg_quick_update = 1'b1;
   logic cfg_invert_pixels = 1'b0;
   logic cfg_col_swap = 1'b0;
   logic cfg_row_swap = 1'b0;

   column_req_type column_queue[$];
   flip_cmd_type   flip_queue[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int columns_queued = 0;
   int columns_accepted = 0;
   int flips_checked = 0;
   int error_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   flipdot_delta_column_update_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_column_index    (req_column_index),
      .req_new_column_bits (req_new_column_bits),
      .req_old_column_bits (req_old_column_bits),
      .req_have_old        (req_have_old),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_column_address  (rsp_column_address),
      .rsp_row_line        (rsp_row_line),
      .rsp_yellow          (rsp_yellow),
      .rsp_panel_index     (rsp_panel_index),
      .rsp_last_flip       (rsp_last_flip),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   // Queue the flip commands that one accepted column request should produce.
   function automatic void predict_flips(input logic [COL_W-1:0] col,
                                         input logic [BITS_W-1:0] new_bits,
                                         input logic [BITS_W-1:0] old_bits,
                                         input logic have_old);
      logic [BITS_W-1:0] flip_mask;
      int                pos;
      int                top_row;
      flip_cmd_type      cmd;
      if (col >= MATRIX_COLUMNS) return;
      // Delta mode flips only the rows whose bit changed; otherwise flip every row.
      flip_mask = (cfg_quick_update && have_old) ? (new_bits ^ old_bits) : '1;
      top_row = -1;
      for (int row = 0; row < MATRIX_ROWS; row++) begin
         if (flip_mask[row]) top_row = row;
      end
      // Mirror, then reverse the column, wrap it within a panel, skip every eighth slot.
      pos = col;
      if (cfg_col_swap) pos = MATRIX_COLUMNS - 1 - pos;
      pos = (MATRIX_COLUMNS - 1 - pos) % PANEL_COLUMNS;
      for (int row = 0; row <= top_row; row++) begin
         if (flip_mask[row]) begin
            cmd.column_address = ADDR_W'(pos + pos / SKIP_SPAN + 1);
            cmd.row_line       = LINE_W'(cfg_row_swap ? row : MATRIX_ROWS - 1 - row);
            cmd.yellow         = new_bits[row] ^ cfg_invert_pixels;
            cmd.panel_index    = PANEL_W'(col / PANEL_COLUMNS);
            cmd.last_flip      = (row == top_row);
            flip_queue.push_back(cmd);
         end
      end
   endfunction

   function automatic void check_field(input string name, input int expected_value,
                                       input int actual_value);
      if (expected_value != actual_value) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected_value, actual_value);
         error_count++;
      end
   endfunction

   // Mostly in-range columns whose old bits differ from the new ones in a bit or two,
   // with unchanged columns, unrelated old bits and out-of-range columns mixed in.
   function automatic column_req_type random_column();
      column_req_type req;
      int             mode;
      mode = $urandom_range(99);
      if (mode < 6)
         req.column_index = COL_W'($urandom_range(MATRIX_COLUMNS, (1 << COL_W) - 1));
      else
         req.column_index = COL_W'($urandom_range(MATRIX_COLUMNS - 1, 0));
      mode = $urandom_range(99);
      if (mode < 5)
         req.new_column_bits = '0;
      else if (mode < 10)
         req.new_column_bits = '1;
      else
         req.new_column_bits = BITS_W'($urandom);
      req.have_old = ($urandom_range(99) < 75);
      mode = $urandom_range(99);
      if (mode < 12)
         req.old_column_bits = req.new_column_bits;
      else if (mode < 30)
         req.old_column_bits = BITS_W'($urandom);
      else if (mode < 65)
         req.old_column_bits = req.new_column_bits ^ (BITS_W'(1) << $urandom_range(15));
      else
         req.old_column_bits = req.new_column_bits ^ (BITS_W'(1) << $urandom_range(15))
                             ^ (BITS_W'(1) << $urandom_range(15));
      return req;
   endfunction

   function automatic void queue_column(input logic [COL_W-1:0] col,
                                        input logic [BITS_W-1:0] new_bits,
                                        input logic [BITS_W-1:0] old_bits,
                                        input logic have_old);
      column_req_type req;
      req.column_index    = col;
      req.new_column_bits = new_bits;
      req.old_column_bits = old_bits;
      req.have_old        = have_old;
      column_queue.push_back(req);
      columns_queued++;
   endfunction

   // Write one register and hold until the write is taken; mirror it in the shadow copy.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         fdcu_pkg::CSR_QUICK_UPDATE:  cfg_quick_update  = value;
         fdcu_pkg::CSR_INVERT_PIXELS: cfg_invert_pixels = value;
         fdcu_pkg::CSR_COL_SWAP:      cfg_col_swap      = value;
         fdcu_pkg::CSR_ROW_SWAP:      cfg_row_swap      = value;
         default: ;
      endcase
   endtask

   // Wait until every queued request is taken and every flip command checked,
   // then give empty columns still in the block time to finish.
   task automatic settle();
      while (columns_accepted != columns_queued || flip_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic quick, input logic invert, input logic cswap,
                            input logic rswap, input int sender_idle, input int receiver_stall,
                            input int count);
      write_reg(fdcu_pkg::CSR_QUICK_UPDATE, quick);
      write_reg(fdcu_pkg::CSR_INVERT_PIXELS, invert);
      write_reg(fdcu_pkg::CSR_COL_SWAP, cswap);
      write_reg(fdcu_pkg::CSR_ROW_SWAP, rswap);
      sender_idle_pct    = sender_idle;
      receiver_stall_pct = receiver_stall;
      repeat (count) begin
         column_queue.push_back(random_column());
         columns_queued++;
      end
      settle();
   endtask

   // Request driver: offer queued columns, hold each until taken, and predict on accept.
   always @(posedge clock) begin : column_driver
      column_req_type staged;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_flips(req_column_index, req_new_column_bits, req_old_column_bits,
                          req_have_old);
            columns_accepted <= columns_accepted + 1;
         end
         // A pending request stays on the bus untouched until it is taken.
         if (!req_valid || req_ready) begin
            if (column_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               staged = column_queue.pop_front();
               req_valid           <= 1'b1;
               req_column_index    <= staged.column_index;
               req_new_column_bits <= staged.new_column_bits;
               req_old_column_bits <= staged.old_column_bits;
               req_have_old        <= staged.have_old;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Flip command receiver: random stalls, plus one long hold-off early in the run
   // while the driver keeps offering, so the block backs up into its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && columns_accepted >= HOLD_TRIGGER) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Monitor: compare each flip command taken against the oldest prediction.
   always @(posedge clock) begin : flip_monitor
      flip_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (flip_queue.size() == 0) begin
            $error("unexpected flip command: addr %0d line %0d yellow %0d panel %0d last %0d",
                   rsp_column_address, rsp_row_line, rsp_yellow, rsp_panel_index,
                   rsp_last_flip);
            error_count++;
         end else begin
            want = flip_queue.pop_front();
            check_field("column_address", want.column_address, rsp_column_address);
            check_field("row_line", want.row_line, rsp_row_line);
            check_field("yellow", want.yellow, rsp_yellow);
            check_field("panel_index", want.panel_index, rsp_panel_index);
            check_field("last_flip", want.last_flip, rsp_last_flip);
         end
         flips_checked++;
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Write to an unused index: must leave quick update on.
      write_reg(CSR_IDX_W'($urandom_range(CSR_REG_COUNT, CSR_IDX_MAX)), 1'b0);

      // Directed columns at reset settings: address wrap edges, skip boundaries,
      // out-of-range columns, unchanged and fully changed columns, single-row changes.
      queue_column(0, 16'hFFFF, 16'h0000, 1'b1);
      queue_column(MATRIX_COLUMNS - 1, 16'h0000, 16'hFFFF, 1'b1);
      queue_column(6, 16'h0001, 16'h0000, 1'b1);
      queue_column(7, 16'h8000, 16'h0000, 1'b1);
      queue_column(13, 16'h0000, 16'h8001, 1'b1);
      queue_column(14, 16'hA5A5, 16'hA5A5, 1'b1);
      queue_column(20, 16'h5A5A, 16'h5A5A, 1'b0);
      queue_column(21, 16'h1234, 16'h1234, 1'b1);
      queue_column(MATRIX_COLUMNS, 16'hFFFF, 16'h0000, 1'b1);
      queue_column(COL_W'((1 << COL_W) - 1), 16'hFFFF, 16'h0000, 1'b0);
      queue_column(16, 16'h0000, 16'h0000, 1'b0);
      queue_column(27, 16'hFFFF, 16'hFFFF, 1'b0);
      queue_column(10, 16'h00FF, 16'hFF00, 1'b1);
      queue_column(22, 16'h8000, 16'h7FFF, 1'b1);
      settle();

      // Random phases across register settings and handshake pressure.
      run_phase(1'b1, 1'b0, 1'b0, 1'b0, 0, 0, 36);
      run_phase(1'b0, 1'b1, 1'b1, 1'b1, 52, 0, 36);
      write_reg(CSR_IDX_W'($urandom_range(CSR_REG_COUNT, CSR_IDX_MAX)), 1'b1);
      run_phase(1'b1, 1'b1, 1'b0, 1'b1, 0, 52, 36);
      run_phase(1'b1, 1'b0, 1'b1, 1'b0, 7, 7, 36);
      run_phase(1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 36);

      if (flip_queue.size() != 0) begin
         $error("%0d flip commands never arrived", flip_queue.size());
         error_count++;
      end

      $display("Covered %0d column requests and %0d flip commands", columns_accepted,
               flips_checked);
      $display("over six phases of register settings, with sender gaps, receiver stalls");
      $display("and a long hold.");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### flipdot_delta_column_update_top.f
+incdir+rtl/core
rtl/core/fdcu_pkg.sv
rtl/core/fdcu_divider.sv
rtl/core/flipdot_delta_column_update_top.sv
rtl/core/fdcu_checker.sv
verif/flipdot_delta_column_update_top_test.sv
